/* rtl/zrle_pkg.sv */
// Shared types, constants and index helpers for the ZRLE tile run decoder.
package zrle_pkg;

	localparam int unsigned TILE_SIDE   = 64;
	localparam int unsigned PAL_ENTRIES = 128;
	localparam int unsigned PAL_AW      = 7;
	localparam logic [12:0] ACC_MAX     = 13'd8191;
	localparam logic [7:0]  LEN_CONT    = 8'd255;

	typedef enum logic [6:0] {
		M_IDLE        = 7'b0000001,
		M_LOAD_PACKED = 7'b0000010,
		M_LOAD_RLE    = 7'b0000100,
		M_RAW         = 7'b0001000,
		M_PACKED      = 7'b0010000,
		M_PLAIN_RLE   = 7'b0100000,
		M_PAL_RLE     = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] addr;
		logic [23:0]       data;
	} pal_wr_t;

	// palette index of one slot of a packed byte, most significant slot first
	function automatic logic [PAL_AW-1:0] idx_of(input logic [7:0] b, input logic [6:0] cnt,
			input logic [2:0] slot);
		logic [7:0] sh;
		logic [PAL_AW-1:0] r;
		sh = b;
		if (cnt > 7'd16) begin
			r = b[6:0];
		end else if (cnt > 7'd4) begin
			sh = b << {slot[0], 2'b00};
			r = {3'b000, sh[7:4]};
		end else if (cnt > 7'd2) begin
			sh = b << {slot[1:0], 1'b0};
			r = {5'b00000, sh[7:6]};
		end else begin
			sh = b << slot;
			r = {6'b000000, sh[7]};
		end
		return r;
	endfunction

	function automatic logic [2:0] last_slot(input logic [6:0] cnt);
		logic [2:0] r;
		if (cnt > 7'd16)     r = 3'd0;
		else if (cnt > 7'd4) r = 3'd1;
		else if (cnt > 7'd2) r = 3'd3;
		else                 r = 3'd7;
		return r;
	endfunction

	function automatic logic [6:0] clamp_side(input logic [6:0] v);
		logic [6:0] r;
		if (v == 7'd0)                 r = 7'd1;
		else if (v > 7'(TILE_SIDE))    r = 7'(TILE_SIDE);
		else                           r = v;
		return r;
	endfunction

endpackage

/* rtl/zrle_pal_ram.sv */
// Palette memory with per-entry valid bits, registered read and write forwarding.
module zrle_pal_ram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  zrle_pkg::pal_wr_t             wr,
	input  logic [zrle_pkg::PAL_AW-1:0]   rd_addr,
	output logic [23:0]                   rd_data
);
	import zrle_pkg::*;

	logic [23:0]            mem [PAL_ENTRIES];
	logic [PAL_ENTRIES-1:0] vld_q;
	logic [23:0]            mem_rd_q;
	logic [23:0]            fwd_data_q;
	logic                   fwd_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		mem_rd_q   <= mem[rd_addr];
		fwd_data_q <= wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			fwd_q    <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			fwd_q    <= wr.en && (wr.addr == rd_addr);
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : (rd_vld_q ? mem_rd_q : 24'd0);

endmodule

/* rtl/zrle_tile_run_decoder_core.sv */
// Top level of the ZRLE tile run decoder: input register, byte decoder, result register.
//
// channel | dir | tdata (low bit up)                             | tuser           | tlast
// s_*     | in  | data_byte, tile_width, tile_height            | tile_start      | -
// m_*     | out | run_start, run_length, red, green, blue        | tile_done, clipped | last
//
// One input byte per cycle unless stalled; a packed-index byte gives 1 to 8 runs,
// one per slot, and is held until its last. A palette-indexed byte whose index was
// not guessed at input transfer waits for the palette memory read.
// Reset clears control state and palette valid bits at once; no clearing pass.
// Output stalls hold the byte in the input register and back-pressure s_tready.
module zrle_tile_run_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // data_byte[7:0], tile_width[14:8], tile_height[21:15], zero
	input  logic        s_tuser,   // tile_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // run_start[11:0], run_length[24:12], red, green, blue, zero
	output logic [1:0]  m_tuser,   // tile_done, clipped
	output logic        m_tlast    // last
);
	import zrle_pkg::*;

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic [6:0]  w_s1;
	logic [6:0]  h_s1;

	mode_t       mode_q, mode_n;
	logic [6:0]  cnt_q, cnt_n;
	logic [12:0] pos_q;
	logic [6:0]  col_q, col_n;
	logic [1:0]  phase_q, phase_n;
	logic [23:0] pend_q, pend_n;
	logic [12:0] acc_q, acc_n;
	logic [6:0]  width_q, width_n;
	logic [12:0] total_q, total_n;
	logic [2:0]  slot_q, slot_n;
	logic [PAL_AW-1:0] tag_q;
	logic        tag_vld_q;

	logic        need_rd, hit, out_free, proc, consume;
	logic [PAL_AW-1:0] need_addr, rd_addr;
	logic [23:0] pal_data;
	pal_wr_t     pal_wr;

	logic        emit, last;
	logic [12:0] coded;
	logic [23:0] color;
	logic [12:0] rem, len, pos_n;
	logic        clip, done;
	logic [13:0] sum14;
	logic [12:0] acc_sat;
	logic [6:0]  dw, dh;
	logic [13:0] area;
	logic [7:0]  col_inc;
	logic        pk_done;

	logic        m_tvalid_q;
	logic [11:0] run_start_q;
	logic [12:0] run_len_q;
	logic [23:0] color_q;
	logic        done_q, clip_q, last_q;

	zrle_pal_ram u_pal (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (pal_wr),
		.rd_addr (rd_addr),
		.rd_data (pal_data)
	);

	assign need_rd   = vld_s1 && !start_s1
		&& (mode_q == M_PACKED || (mode_q == M_PAL_RLE && phase_q == 2'd0));
	assign need_addr = (mode_q == M_PACKED) ? idx_of(byte_s1, cnt_q, slot_q) : byte_s1[6:0];
	assign hit       = tag_vld_q && (tag_q == need_addr);
	assign out_free  = !m_tvalid_q || m_tready;
	assign proc      = vld_s1 && out_free && (!need_rd || hit);
	assign s_tready  = !vld_s1 || (proc && consume);

	always_comb begin
		if (vld_s1 && !proc) begin
			rd_addr = need_addr;
		end else if (proc && !consume) begin
			rd_addr = idx_of(byte_s1, cnt_q, slot_q + 3'd1);
		end else if (mode_q == M_PACKED || mode_q == M_LOAD_PACKED) begin
			rd_addr = idx_of(s_tdata[7:0], cnt_q, 3'd0);
		end else begin
			rd_addr = s_tdata[6:0];
		end
	end

	assign sum14   = {1'b0, acc_q} + {6'd0, byte_s1};
	assign acc_sat = (sum14 > {1'b0, ACC_MAX}) ? ACC_MAX : sum14[12:0];
	assign dw      = clamp_side(w_s1);
	assign dh      = clamp_side(h_s1);
	assign area    = dw * dh;
	assign col_inc = {1'b0, col_q} + 8'd1;
	assign pk_done = (pos_q + 13'd1) >= total_q;

	always_comb begin
		mode_n  = mode_q;
		cnt_n   = cnt_q;
		col_n   = col_q;
		phase_n = phase_q;
		pend_n  = pend_q;
		acc_n   = acc_q;
		width_n = width_q;
		total_n = total_q;
		slot_n  = 3'd0;
		emit    = 1'b0;
		last    = 1'b1;
		consume = 1'b1;
		coded   = 13'd1;
		color   = pend_q;
		pal_wr  = '{en: 1'b0, addr: col_q, data: {pend_q[15:0], byte_s1}};
		if (start_s1) begin
			width_n = dw;
			total_n = area[12:0];
			cnt_n   = byte_s1[6:0];
			col_n   = 7'd0;
			phase_n = 2'd0;
			pend_n  = 24'd0;
			acc_n   = 13'd0;
			if (byte_s1[6:0] == 7'd0) begin
				mode_n = byte_s1[7] ? M_PLAIN_RLE : M_RAW;
			end else begin
				mode_n = byte_s1[7] ? M_LOAD_RLE : M_LOAD_PACKED;
			end
		end else begin
			unique case (mode_q)
				M_LOAD_PACKED, M_LOAD_RLE: begin
					pend_n = {pend_q[15:0], byte_s1};
					if (phase_q == 2'd2) begin
						phase_n   = 2'd0;
						pal_wr.en = 1'b1;
						if (col_inc < {1'b0, cnt_q}) begin
							col_n = col_inc[6:0];
						end else begin
							col_n = 7'd0;
							if (cnt_q == 7'd1) begin
								emit  = 1'b1;
								color = pend_n;
								coded = total_q;
							end else begin
								mode_n = (mode_q == M_LOAD_RLE) ? M_PAL_RLE : M_PACKED;
							end
						end
					end else begin
						phase_n = phase_q + 2'd1;
					end
				end
				M_RAW: begin
					pend_n = {pend_q[15:0], byte_s1};
					if (phase_q == 2'd2) begin
						phase_n = 2'd0;
						emit    = 1'b1;
						color   = pend_n;
					end else begin
						phase_n = phase_q + 2'd1;
					end
				end
				M_PACKED: begin
					emit  = 1'b1;
					color = pal_data;
					if (col_inc >= {1'b0, width_q}) begin
						col_n = 7'd0;
					end else begin
						col_n = col_inc[6:0];
					end
					last    = (col_inc >= {1'b0, width_q}) || pk_done
						|| (slot_q == last_slot(cnt_q));
					consume = last;
					slot_n  = last ? 3'd0 : slot_q + 3'd1;
				end
				M_PLAIN_RLE: begin
					if (phase_q != 2'd3) begin
						pend_n  = {pend_q[15:0], byte_s1};
						phase_n = phase_q + 2'd1;
						if (phase_q == 2'd2) begin
							acc_n = 13'd1;
						end
					end else if (byte_s1 != LEN_CONT) begin
						emit    = 1'b1;
						coded   = acc_sat;
						phase_n = 2'd0;
						acc_n   = 13'd0;
					end else begin
						acc_n = acc_sat;
					end
				end
				M_PAL_RLE: begin
					if (phase_q == 2'd0) begin
						pend_n = pal_data;
						color  = pal_data;
						if (byte_s1[7]) begin
							phase_n = 2'd1;
							acc_n   = 13'd1;
						end else begin
							emit = 1'b1;
						end
					end else if (byte_s1 != LEN_CONT) begin
						emit    = 1'b1;
						coded   = acc_sat;
						phase_n = 2'd0;
						acc_n   = 13'd0;
					end else begin
						acc_n = acc_sat;
					end
				end
				default: begin
				end
			endcase
		end
		if (!proc) begin
			pal_wr.en = 1'b0;
		end
	end

	assign rem   = total_q - pos_q;
	assign clip  = coded > rem;
	assign len   = clip ? rem : coded;
	assign pos_n = pos_q + len;
	assign done  = pos_n >= total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			mode_q    <= M_IDLE;
			cnt_q     <= '0;
			pos_q     <= '0;
			col_q     <= '0;
			phase_q   <= '0;
			pend_q    <= '0;
			acc_q     <= '0;
			width_q   <= '0;
			total_q   <= '0;
			slot_q    <= '0;
			tag_q     <= '0;
			tag_vld_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			tag_q     <= rd_addr;
			tag_vld_q <= 1'b1;
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (proc) begin
				cnt_q   <= cnt_n;
				col_q   <= col_n;
				phase_q <= phase_n;
				pend_q  <= pend_n;
				acc_q   <= acc_n;
				width_q <= width_n;
				total_q <= total_n;
				slot_q  <= slot_n;
				if (start_s1) begin
					pos_q  <= 13'd0;
					mode_q <= mode_n;
				end else if (emit) begin
					pos_q  <= pos_n;
					mode_q <= done ? M_IDLE : mode_n;
				end else begin
					mode_q <= mode_n;
				end
			end
			if (out_free) begin
				m_tvalid_q <= proc && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata[7:0];
			w_s1     <= s_tdata[14:8];
			h_s1     <= s_tdata[21:15];
			start_s1 <= s_tuser;
		end
		if (out_free && proc && emit) begin
			run_start_q <= pos_q[11:0];
			run_len_q   <= len;
			color_q     <= color;
			done_q      <= done;
			clip_q      <= clip;
			last_q      <= last || done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, color_q[7:0], color_q[15:8], color_q[23:16], run_len_q, run_start_q};
	assign m_tuser  = {clip_q, done_q};
	assign m_tlast  = last_q;

endmodule

/* rtl/zrle_checker.sv */
// Port-level checks for the ZRLE tile run decoder and their binding.
module zrle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	logic [13:0] run_end;
	assign run_end = {2'b00, m_tdata[11:0]} + {1'b0, m_tdata[24:12]};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[24:12] != 13'd0)
		else $error("empty run");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> run_end <= 14'd4096)
		else $error("run passes tile end");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("tile end not last of its byte");

	a_clip_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("clipped run does not end the tile");

endmodule

bind zrle_tile_run_decoder_core zrle_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
